/* design/hssp_pkg.sv */
// Package for the SPS size parser: controller states, step codes, command and status structs.
// No dependencies.
package hssp_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BITS,
      ST_FINISH,
      ST_OUT
   } ctrl_state_type;

   localparam logic [4:0] STEP_DONE = 5'd27;

   typedef struct packed {
      logic load_byte;
      logic shift_bit;
      logic finish_step;
      logic clear_all;
   } dp_cmd_type;

   typedef struct packed {
      logic finished;
   } dp_status_type;

   function automatic logic [5:0] step_width(input logic [4:0] s);
      unique case (s)
         5'd0, 5'd1, 5'd2: step_width = 6'd8;
         5'd5, 5'd8, 5'd9, 5'd13, 5'd18, 5'd20, 5'd24, 5'd25, 5'd26:
            step_width = 6'd1;
         default: step_width = 6'd0;
      endcase
   endfunction

   function automatic logic is_high_profile(input logic [7:0] p);
      is_high_profile = (p == 8'd100) || (p == 8'd110) || (p == 8'd122) ||
                        (p == 8'd244) || (p == 8'd44) || (p == 8'd83) ||
                        (p == 8'd86) || (p == 8'd118) || (p == 8'd128) ||
                        (p == 8'd138) || (p == 8'd139) || (p == 8'd134) ||
                        (p == 8'd135);
   endfunction

endpackage

/* design/hssp_if.sv */
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface hssp_if #(parameter int Width = 8) (input logic clock);
   logic             valid;
   logic             ready;
   logic [Width-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* design/hssp_datapath.sv */
// Bit reader, emulation-prevention filter and SPS field walker.
// Depends on hssp_pkg.
module hssp_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  hssp_pkg::dp_cmd_type   cmd,
   input  logic [7:0]             in_byte,
   output hssp_pkg::dp_status_type status,
   output logic                   byte_used,
   output logic [7:0]             profile_out,
   output logic [7:0]             level_out,
   output logic [15:0]            width_out,
   output logic [15:0]            height_out,
   output logic                   long_enough
);
   logic [1:0]  zrun_ff, zrun_in;
   logic [2:0]  seen_ff, seen_in;
   logic [7:0]  sh_ff, sh_in;
   logic [4:0]  step_ff, step_in;
   logic [5:0]  zc_ff, zc_in;
   logic [31:0] fv_ff, fv_in;
   logic [5:0]  left_ff, left_in;
   logic        gact_ff, gact_in, gsuf_ff, gsuf_in;
   logic [7:0]  prof_ff, prof_in, lev_ff, lev_in;
   logic        c444_ff, c444_in;
   logic [31:0] loop_ff, loop_in;
   logic [3:0]  li_ff, li_in;
   logic [7:0]  lsc_ff, lsc_in;
   logic [11:0] wu_ff, wu_in, hu_ff, hu_in;
   logic        fo_ff, fo_in, fin_ff, fin_in;

   logic        bit_b, done, skip;
   logic [31:0] dv, shifted;
   logic [4:0]  nstep;
   logic [7:0]  nsc;
   logic [31:0] delta;
   logic [3:0]  li_nx;

   assign skip      = (seen_ff == 3'd0) || (zrun_ff == 2'd2 && in_byte == 8'd3);
   assign byte_used = !skip;
   assign bit_b     = sh_ff[7];

   always_comb begin
      zrun_in = zrun_ff; seen_in = seen_ff; sh_in = sh_ff; step_in = step_ff;
      zc_in = zc_ff; fv_in = fv_ff; left_in = left_ff; gact_in = gact_ff;
      gsuf_in = gsuf_ff; prof_in = prof_ff; lev_in = lev_ff; c444_in = c444_ff;
      loop_in = loop_ff; li_in = li_ff; lsc_in = lsc_ff; wu_in = wu_ff;
      hu_in = hu_ff; fo_in = fo_ff; fin_in = fin_ff;
      done = 1'b0; dv = '0; nstep = step_ff; nsc = 8'd0; delta = '0;
      li_nx = li_ff + 4'd1; shifted = {fv_ff[30:0], bit_b};

      if (cmd.load_byte) begin
         if (seen_ff != 3'd0) begin
            if (zrun_ff == 2'd2 && in_byte == 8'd3) zrun_in = 2'd0;
            else if (in_byte == 8'd0) zrun_in = (zrun_ff == 2'd2) ? 2'd2 : zrun_ff + 2'd1;
            else zrun_in = 2'd0;
         end
         if (seen_ff < 3'd4) seen_in = seen_ff + 3'd1;
         sh_in = in_byte;
      end else if (cmd.shift_bit && !fin_ff) begin
         sh_in = {sh_ff[6:0], 1'b0};
         if (gact_ff && !gsuf_ff) begin
            if (!bit_b) begin
               zc_in = zc_ff + 6'd1;
               if (zc_ff == 6'd31) done = 1'b1;
            end else if (zc_ff == 6'd0) begin
               done = 1'b1;
            end else begin
               gsuf_in = 1'b1; fv_in = 32'd1; left_in = zc_ff;
            end
         end else begin
            fv_in = shifted; left_in = left_ff - 6'd1;
            if (left_ff == 6'd1) begin
               done = 1'b1; dv = gact_ff ? shifted - 32'd1 : shifted;
            end
         end
      end else if (cmd.finish_step && !fin_ff) begin
         // end of data: remaining bits are zero
         done = 1'b1;
         if (gact_ff && !gsuf_ff) dv = (32'd1 << zc_ff) - 32'd1;
         else if (gact_ff) dv = (fv_ff << left_ff) - 32'd1;
         else dv = fv_ff << left_ff;
      end

      if (done) begin
         unique case (step_ff)
            5'd0: begin prof_in = dv[7:0]; nstep = 5'd1; end
            5'd1: nstep = 5'd2;
            5'd2: begin lev_in = dv[7:0]; nstep = 5'd3; end
            5'd3: nstep = hssp_pkg::is_high_profile(prof_ff) ? 5'd4 : 5'd10;
            5'd4: begin c444_in = (dv == 32'd3); nstep = (dv == 32'd3) ? 5'd5 : 5'd6; end
            5'd5: nstep = 5'd6;
            5'd6: nstep = 5'd7;
            5'd7: nstep = 5'd8;
            5'd8: nstep = 5'd9;
            5'd9: if (dv != 0) begin li_in = 4'd0; nstep = 5'd20; end else nstep = 5'd10;
            5'd20: begin
               if (dv != 0) begin
                  loop_in = (li_ff < 4'd6) ? 32'd16 : 32'd64;
                  lsc_in = 8'd8; nstep = 5'd21;
               end else begin
                  li_in = li_nx;
                  nstep = (li_nx < (c444_ff ? 4'd12 : 4'd8)) ? 5'd20 : 5'd10;
               end
            end
            5'd21: begin
               delta = dv[0] ? ({1'b0, dv[31:1]} + 32'd1) : (32'd0 - {1'b0, dv[31:1]});
               nsc = lsc_ff + delta[7:0];
               if (nsc != 8'd0) lsc_in = nsc;
               loop_in = loop_ff - 32'd1;
               if (loop_ff == 32'd1 || nsc == 8'd0) begin
                  li_in = li_nx;
                  nstep = (li_nx < (c444_ff ? 4'd12 : 4'd8)) ? 5'd20 : 5'd10;
               end
            end
            5'd10: nstep = 5'd11;
            5'd11: nstep = (dv == 0) ? 5'd12 : (dv == 32'd1) ? 5'd13 : 5'd17;
            5'd12: nstep = 5'd17;
            5'd13: nstep = 5'd14;
            5'd14: nstep = 5'd15;
            5'd15: nstep = 5'd16;
            5'd16: begin loop_in = dv; nstep = (dv == 0) ? 5'd17 : 5'd22; end
            5'd22: begin loop_in = loop_ff - 32'd1; if (loop_ff == 32'd1) nstep = 5'd17; end
            5'd17: nstep = 5'd18;
            5'd18: nstep = 5'd19;
            5'd19: begin wu_in = dv[11:0] + 12'd1; nstep = 5'd23; end
            5'd23: begin hu_in = dv[11:0] + 12'd1; nstep = 5'd24; end
            5'd24: begin fo_in = dv[0]; nstep = (dv != 0) ? 5'd26 : 5'd25; end
            5'd25: nstep = 5'd26;
            default: begin fin_in = 1'b1; nstep = hssp_pkg::STEP_DONE; end
         endcase
         // after end of data, loops close at once
         if (cmd.finish_step && nstep != hssp_pkg::STEP_DONE) begin
            if (nstep == 5'd20 || nstep == 5'd21) nstep = 5'd10;
            else if (nstep == 5'd22) nstep = 5'd17;
         end
         step_in = nstep;
         if (nstep != hssp_pkg::STEP_DONE) begin
            fv_in = '0; zc_in = '0; gsuf_in = 1'b0;
            left_in = hssp_pkg::step_width(nstep);
            gact_in = (hssp_pkg::step_width(nstep) == 6'd0);
         end
      end

      if (cmd.clear_all) begin
         zrun_in = '0; seen_in = '0; step_in = '0; zc_in = '0; fv_in = '0;
         left_in = 6'd8; gact_in = 1'b0; gsuf_in = 1'b0; prof_in = '0; lev_in = '0;
         c444_in = 1'b0; loop_in = '0; li_in = '0; lsc_in = 8'd8; wu_in = '0;
         hu_in = '0; fo_in = 1'b0; fin_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zrun_ff <= '0; seen_ff <= '0; step_ff <= '0; zc_ff <= '0; fv_ff <= '0;
         left_ff <= 6'd8; gact_ff <= 1'b0; gsuf_ff <= 1'b0; prof_ff <= '0;
         lev_ff <= '0; c444_ff <= 1'b0; loop_ff <= '0; li_ff <= '0;
         lsc_ff <= 8'd8; wu_ff <= '0; hu_ff <= '0; fo_ff <= 1'b0; fin_ff <= 1'b0;
         sh_ff <= '0;
      end else begin
         zrun_ff <= zrun_in; seen_ff <= seen_in; step_ff <= step_in; zc_ff <= zc_in;
         fv_ff <= fv_in; left_ff <= left_in; gact_ff <= gact_in; gsuf_ff <= gsuf_in;
         prof_ff <= prof_in; lev_ff <= lev_in; c444_ff <= c444_in; loop_ff <= loop_in;
         li_ff <= li_in; lsc_ff <= lsc_in; wu_ff <= wu_in; hu_ff <= hu_in;
         fo_ff <= fo_in; fin_ff <= fin_in; sh_ff <= sh_in;
      end
   end

   assign status.finished = fin_ff;
   assign long_enough = (seen_ff == 3'd4);
   assign profile_out = prof_ff;
   assign level_out   = lev_ff;
   assign width_out   = {wu_ff, 4'd0};
   assign height_out  = fo_ff ? {hu_ff, 4'd0} : {hu_ff[10:0], 5'd0};
endmodule

/* design/hssp_ctrl.sv */
// Controller FSM: sequences byte load, eight bit shifts, end-of-data finish and result.
// Depends on hssp_pkg.
module hssp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic                    in_last,
   input  logic                    byte_used,
   input  logic                    long_enough,
   input  hssp_pkg::dp_status_type status,
   input  logic                    out_free,
   output logic                    in_ready,
   output hssp_pkg::dp_cmd_type    cmd,
   output logic                    emit
);
   hssp_pkg::ctrl_state_type state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       last_ff, last_in;
   logic       accept;

   assign accept = in_valid && in_ready;

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; last_in = last_ff;
      unique case (state_ff)
         hssp_pkg::ST_IDLE: if (accept) begin
            last_in = in_last; cnt_in = 3'd0;
            if (byte_used) state_in = hssp_pkg::ST_BITS;
            else if (in_last) state_in = hssp_pkg::ST_FINISH;
         end
         hssp_pkg::ST_BITS: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7)
               state_in = last_ff ? hssp_pkg::ST_FINISH : hssp_pkg::ST_IDLE;
         end
         hssp_pkg::ST_FINISH:
            if (status.finished || !long_enough) state_in = hssp_pkg::ST_OUT;
         hssp_pkg::ST_OUT: if (out_free) state_in = hssp_pkg::ST_IDLE;
         default: state_in = hssp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0; emit = 1'b0;
      in_ready = (state_ff == hssp_pkg::ST_IDLE);
      unique case (state_ff)
         hssp_pkg::ST_IDLE:   cmd.load_byte = accept;
         hssp_pkg::ST_BITS:   cmd.shift_bit = 1'b1;
         hssp_pkg::ST_FINISH: cmd.finish_step = long_enough;
         hssp_pkg::ST_OUT:    if (out_free) begin emit = 1'b1; cmd.clear_all = 1'b1; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hssp_pkg::ST_IDLE; cnt_ff <= '0; last_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; last_ff <= last_in;
      end
   end
endmodule

/* design/h264_sps_size_parser_core.sv */
// SPS size parser top level: controller, datapath and a result register.
// Flow: a data byte is accepted and then shifted into the field reader bit by bit; the header
// or a dropped escape byte is only accepted. After the last byte the finish state closes the
// open fields until the walk ends, and the result beat is then handed to the result register.
// A new byte is taken only after the reader has shifted in every bit of the last one.
// Reset: synchronous, active high; clears the controller, the parse state and the result valid flag.
module h264_sps_size_parser_core (
   input logic clock,
   input logic reset,
   hssp_if.sink   req,
   hssp_if.source rsp
);
   hssp_pkg::dp_cmd_type    cmd;
   hssp_pkg::dp_status_type status;
   logic        byte_used, long_enough, emit, out_free;
   logic [7:0]  prof, lev;
   logic [15:0] wid, hgt;
   logic        rsp_valid_ff;
   logic [48:0] rsp_data_ff;

   // result register: free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp.ready;

   hssp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req.valid), .in_last(req.payload[0]),
      .byte_used(byte_used), .long_enough(long_enough), .status(status),
      .out_free(out_free), .in_ready(req.ready), .cmd(cmd), .emit(emit)
   );

   hssp_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .in_byte(req.payload[8:1]),
      .status(status), .byte_used(byte_used), .profile_out(prof), .level_out(lev),
      .width_out(wid), .height_out(hgt), .long_enough(long_enough)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // zero the payload for short units
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= long_enough ? {prof, lev, wid, hgt, 1'b1} : 49'd0;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;
endmodule

/* design/hssp_checker.sv */
// Port-level checker for the SPS size parser, bound to the top level.
// Depends on h264_sps_size_parser_core through the bind below.
module hssp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [48:0] rsp_payload
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat dropped or changed while stalled");
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid right after reset");
   a_short_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload[0] |-> rsp_payload[48:1] == 48'd0)
      else $error("short unit result not zero");
   a_handshake_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_ready, rsp_valid}))
      else $error("handshake output unknown");
endmodule

bind h264_sps_size_parser_core hssp_checker u_checker (
   .clock(clock), .reset(reset), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);

/* sim/tb_h264_sps_size_parser_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for h264_sps_size_parser_core: SPS byte beats in, size beats out.
// Depends on hssp_pkg, hssp_if and the core; the expected sizes come from an in-bench predictor.
module tb_h264_sps_size_parser_core;

   localparam int SendTarget = 1050;
   localparam int HoldCycles = 500;

   // Size report of one SPS, packed in the order of the rsp payload.
   typedef struct packed {
      logic [7:0]  profile_code;
      logic [7:0]  level_code;
      logic [15:0] frame_width;
      logic [15:0] frame_height;
      logic        parse_ok;
   } sps_size_type;

   // One row of the directed table; has_size marks a size typed in by hand.
   typedef struct {
      logic [7:0]   data_byte;
      bit           last_byte;
      bit           has_size;
      sps_size_type size;
   } byte_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hssp_if #(.Width(9))  req_ch (.clock(clock));
   hssp_if #(.Width(49)) rsp_ch (.clock(clock));

   h264_sps_size_parser_core u_top (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor: bit-serial SPS walk, same state as the block
   // ---------------------------------------------------------------------
   int unsigned zero_run, nbytes, step, gzeros, fval, fleft;
   int unsigned prof, lvl, is444, poc_type, loops, list_idx;
   int unsigned last_sc, next_sc, wunits, hunits, frame_only, done;
   bit g_active, g_suffix;

   function automatic int unsigned width_of_step(int unsigned s);
      case (s)
         0, 1, 2: return 8;
         5, 8, 9, 13, 18, 20, 24, 25, 26: return 1;
         default: return 0;
      endcase
   endfunction

   function automatic bit high_profile(int unsigned p);
      return p == 100 || p == 110 || p == 122 || p == 244 || p == 44 || p == 83 ||
             p == 86 || p == 118 || p == 128 || p == 138 || p == 139 || p == 134 ||
             p == 135;
   endfunction

   function automatic void open_field();
      int unsigned w;
      w = width_of_step(step);
      fval = 0;
      gzeros = 0;
      g_suffix = 0;
      g_active = (w == 0);
      fleft = w;
   endfunction

   function automatic void advance_list();
      list_idx = (list_idx + 1) & 4'hF;
      step = (list_idx < (is444 ? 12 : 8)) ? 20 : 10;
   endfunction

   function automatic void close_field(int unsigned v);
      int unsigned delta;
      case (step)
         0: begin prof = v & 8'hFF; step = 1; end
         1: step = 2;
         2: begin lvl = v & 8'hFF; step = 3; end
         3: step = high_profile(prof) ? 4 : 10;
         4: begin is444 = (v == 3); step = is444 ? 5 : 6; end
         5: step = 6;
         6: step = 7;
         7: step = 8;
         8: step = 9;
         9: if (v != 0) begin list_idx = 0; step = 20; end else step = 10;
         20: if (v != 0) begin
               loops = (list_idx < 6) ? 16 : 64;
               last_sc = 8;
               next_sc = 8;
               step = 21;
            end else advance_list();
         21: begin
            delta = (v & 1) ? (v / 2 + 1) : (0 - v / 2);
            next_sc = (last_sc + delta) & 8'hFF;
            if (next_sc != 0) last_sc = next_sc;
            loops--;
            if (loops == 0 || next_sc == 0) advance_list();
         end
         10: step = 11;
         11: begin
            poc_type = (v > 1) ? 2 : v;
            step = (v == 0) ? 12 : (v == 1) ? 13 : 17;
         end
         12: step = 17;
         13: step = 14;
         14: step = 15;
         15: step = 16;
         16: begin loops = v; step = (v == 0) ? 17 : 22; end
         22: begin loops--; if (loops == 0) step = 17; end
         17: step = 18;
         18: step = 19;
         19: begin wunits = (v + 1) & 12'hFFF; step = 23; end
         23: begin hunits = (v + 1) & 12'hFFF; step = 24; end
         24: begin frame_only = v & 1; step = (v != 0) ? 26 : 25; end
         25: step = 26;
         default: begin done = 1; step = hssp_pkg::STEP_DONE; return; end
      endcase
      open_field();
   endfunction

   function automatic void shift_in(int unsigned b);
      if (done != 0) return;
      if (g_active && !g_suffix) begin
         if (b == 0) begin
            gzeros++;
            if (gzeros >= 32) close_field(0);
         end else if (gzeros == 0) begin
            close_field(0);
         end else begin
            g_suffix = 1;
            fval = 1;
            fleft = gzeros;
         end
         return;
      end
      fval = (fval << 1) | b;
      fleft--;
      if (fleft == 0) close_field(g_active ? fval - 1 : fval);
   endfunction

   // Past the last byte every bit is zero: close open fields, cut loops short.
   function automatic void drain_fields();
      int unsigned v;
      while (done == 0) begin
         if (g_active && !g_suffix) v = (32'd1 << gzeros) - 1;
         else if (g_active) v = (fval << fleft) - 1;
         else v = fval << fleft;
         close_field(v);
         if (done != 0) break;
         if (step == 20 || step == 21) begin step = 10; open_field(); end
         else if (step == 22) begin step = 17; open_field(); end
      end
   endfunction

   function automatic void clear_parse();
      zero_run = 0; nbytes = 0; step = 0; prof = 0; lvl = 0; is444 = 0;
      poc_type = 0; loops = 0; list_idx = 0; last_sc = 8; next_sc = 8;
      wunits = 0; hunits = 0; frame_only = 0; done = 0;
      open_field();
   endfunction

   // Take one byte; return 1 with the size report when it closes the unit.
   function automatic bit take_sps_byte(logic [7:0] b, bit last, output sps_size_type sz);
      int unsigned h;
      sz = '0;
      if (nbytes != 0) begin
         if (zero_run == 2 && b == 8'h03) zero_run = 0;
         else begin
            for (int i = 7; i >= 0; i--) shift_in(b[i]);
            zero_run = (b == 0) ? ((zero_run < 2) ? zero_run + 1 : 2) : 0;
         end
      end
      if (nbytes < 4) nbytes++;
      if (!last) return 0;
      if (nbytes >= 4) begin
         drain_fields();
         h = hunits * 16 * (frame_only ? 1 : 2);
         sz.profile_code = prof[7:0];
         sz.level_code   = lvl[7:0];
         sz.frame_width  = 16'(wunits * 16);
         sz.frame_height = h[15:0];
         sz.parse_ok     = 1'b1;
      end
      clear_parse();
      return 1;
   endfunction

   // ---------------------------------------------------------------------
   // Bookkeeping shared by the driver and the monitors
   // ---------------------------------------------------------------------
   byte_row_type offered_q[$];   // beats in flight, in offer order
   sps_size_type size_q[$];      // sizes still owed by the block
   int           mismatches = 0;
   int           sizes_seen = 0;
   int           bytes_sent = 0;
   int           burst_left = 0;

   // Offer one byte beat and hold it until accepted; break into bursts.
   task automatic offer_byte(logic [7:0] b, bit last, bit has, sps_size_type sz);
      byte_row_type row;
      bit taken;
      if (burst_left == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 10);
      end
      burst_left--;
      row.data_byte = b; row.last_byte = last; row.has_size = has; row.size = sz;
      offered_q.insert(offered_q.size(), row);
      req_ch.payload = {b, last};
      req_ch.valid   = 1'b1;
      do begin
         @(posedge clock);
         taken = req_ch.ready;
         @(negedge clock);
      end while (!taken);
      bytes_sent++;
   endtask

   // Accepted byte: run the predictor, take the typed size where the row has one.
   always @(posedge clock) begin
      byte_row_type row;
      sps_size_type sz;
      if (!reset && req_ch.valid && req_ch.ready) begin
         row = offered_q.pop_front();
         if (take_sps_byte(req_ch.payload[8:1], req_ch.payload[0], sz))
            size_q.insert(size_q.size(), row.has_size ? row.size : sz);
      end
   end

   // Accepted size beat: compare field by field with the oldest owed size.
   always @(posedge clock) begin
      sps_size_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         sizes_seen++;
         if (size_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected size beat %p", got);
         end else begin
            want = size_q.pop_front();
            if (got.profile_code !== want.profile_code || got.level_code !== want.level_code ||
                got.frame_width !== want.frame_width ||
                got.frame_height !== want.frame_height || got.parse_ok !== want.parse_ok) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("size mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   // Receiver: ready pattern that rotates through always, half and quarter ready, plus one long hold-off
   // while the sender keeps offering, so the block backs up into its input.
   initial begin
      int cyc;
      bit held;
      cyc = 0;
      held = 0;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (1) begin
         if (!held && sizes_seen >= 15) begin
            held = 1;
            rsp_ch.ready = 1'b0;
            repeat (HoldCycles) @(negedge clock);
         end
         case ((cyc / 64) % 3)
            0: rsp_ch.ready = 1'b1;
            1: rsp_ch.ready = $urandom_range(0, 1);
            default: rsp_ch.ready = ($urandom_range(0, 3) == 0);
         endcase
         cyc++;
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // Well-formed SPS generator
   // ---------------------------------------------------------------------
   bit rbsp_q[$];

   function automatic void put_bits(int unsigned v, int n);
      for (int i = n - 1; i >= 0; i--) rbsp_q.insert(rbsp_q.size(), v[i]);
   endfunction

   function automatic void put_ue(int unsigned v);
      int n;
      logic [32:0] code;
      code = 33'(v) + 1;
      n = 0;
      for (int i = 32; i >= 0; i--) if (code[i] && n == 0) n = i + 1;
      repeat (n - 1) rbsp_q.insert(rbsp_q.size(), 1'b0);
      for (int i = n - 1; i >= 0; i--) rbsp_q.insert(rbsp_q.size(), code[i]);
   endfunction

   function automatic int unsigned small_ue();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 4000);
         1: return $urandom;
         default: return $urandom_range(0, 6);
      endcase
   endfunction

   function automatic void build_sps();
      int unsigned profiles[16] = '{66, 77, 88, 100, 110, 122, 244, 44, 83, 86,
                                    118, 128, 138, 139, 134, 135};
      int unsigned p, chroma, lists, poc, cycles;
      rbsp_q.delete();
      p = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : profiles[$urandom_range(0, 15)];
      put_bits(p, 8);
      put_bits($urandom_range(0, 255), 8);
      put_bits($urandom_range(0, 255), 8);
      put_ue($urandom_range(0, 31));
      if (high_profile(p)) begin
         chroma = $urandom_range(0, 3);
         put_ue(chroma);
         if (chroma == 3) put_bits($urandom_range(0, 1), 1);
         put_ue($urandom_range(0, 6));
         put_ue($urandom_range(0, 6));
         put_bits($urandom_range(0, 1), 1);
         if ($urandom_range(0, 2) == 0) begin
            put_bits(1, 1);
            lists = (chroma == 3) ? 12 : 8;
            for (int k = 0; k < lists; k++) begin
               put_bits($urandom_range(0, 1), 1);
               if (rbsp_q[rbsp_q.size() - 1])
                  repeat ($urandom_range(1, 20)) put_ue($urandom_range(0, 40));
            end
         end else put_bits(0, 1);
      end
      put_ue($urandom_range(0, 12));
      poc = $urandom_range(0, 3);
      put_ue(poc);
      if (poc == 0) put_ue($urandom_range(0, 12));
      else if (poc == 1) begin
         put_bits($urandom_range(0, 1), 1);
         put_ue(small_ue());
         put_ue(small_ue());
         cycles = $urandom_range(0, 4);
         put_ue(cycles);
         repeat (cycles) put_ue(small_ue());
      end
      put_ue($urandom_range(0, 16));
      put_bits($urandom_range(0, 1), 1);
      put_ue(($urandom_range(0, 9) == 0) ? $urandom_range(0, 70000) : $urandom_range(0, 200));
      put_ue(($urandom_range(0, 9) == 0) ? $urandom_range(0, 70000) : $urandom_range(0, 200));
      put_bits($urandom_range(0, 1), 1);
      if (!rbsp_q[rbsp_q.size() - 1]) put_bits($urandom_range(0, 1), 1);
      put_bits($urandom_range(0, 1), 1);
      put_bits(1, 1);   // stop bit
      while (rbsp_q.size() % 8 != 0) rbsp_q.insert(rbsp_q.size(), 1'b0);
   endfunction

   // Send the RBSP with escape bytes inserted; sometimes cut the unit short.
   task automatic send_sps();
      logic [7:0] bytes_q[$];
      logic [7:0] b;
      int zeros;
      int cut;
      build_sps();
      bytes_q.insert(bytes_q.size(), ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h67);
      zeros = 0;
      for (int i = 0; i < rbsp_q.size(); i += 8) begin
         for (int j = 0; j < 8; j++) b[7 - j] = rbsp_q[i + j];
         if (zeros == 2 && b <= 8'h03) begin
            bytes_q.insert(bytes_q.size(), 8'h03);
            zeros = 0;
         end
         bytes_q.insert(bytes_q.size(), b);
         zeros = (b == 0) ? zeros + 1 : 0;
      end
      cut = bytes_q.size();
      if ($urandom_range(0, 5) == 0) cut = $urandom_range(1, bytes_q.size());
      for (int i = 0; i < cut; i++) offer_byte(bytes_q[i], i == cut - 1, 0, '0);
   endtask

   // Noise unit: random bytes, zero runs and stray escapes, 1 to 24 bytes long.
   task automatic send_noise();
      int len;
      logic [7:0] b;
      len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 4))
            0: b = 8'h00;
            1: b = 8'h03;
            default: b = 8'($urandom);
         endcase
         offer_byte(b, i == len - 1, 0, '0);
      end
   endtask

   // ---------------------------------------------------------------------
   // Directed table: short units, extremes, escapes, long zero prefix
   // ---------------------------------------------------------------------
   byte_row_type directed[] = '{
      // one-byte unit: too short, all zero
      '{8'h67, 1, 1, '0},
      // three-byte unit: still too short
      '{8'h67, 0, 0, '0}, '{8'h42, 0, 0, '0}, '{8'h1E, 1, 1, '0},
      // four bytes of all ones: max profile and level, every later field reads 0
      '{8'hFF, 0, 0, '0}, '{8'hFF, 0, 0, '0}, '{8'hFF, 0, 0, '0},
      '{8'hFF, 1, 1, '{8'hFF, 8'hFF, 16'd16, 16'd32, 1'b1}},
      // four zero bytes: profile and level 0
      '{8'h00, 0, 0, '0}, '{8'h00, 0, 0, '0}, '{8'h00, 0, 0, '0},
      '{8'h00, 1, 1, '{8'h00, 8'h00, 16'd16, 16'd32, 1'b1}},
      // high profile, escape in the body, long zero prefix
      '{8'h67, 0, 0, '0}, '{8'h64, 0, 0, '0}, '{8'h00, 0, 0, '0},
      '{8'h00, 0, 0, '0}, '{8'h03, 0, 0, '0}, '{8'h00, 0, 0, '0},
      '{8'h00, 0, 0, '0}, '{8'h00, 0, 0, '0}, '{8'h00, 0, 0, '0},
      '{8'h81, 1, 0, '0},
      // escape as the last byte
      '{8'h67, 0, 0, '0}, '{8'h42, 0, 0, '0}, '{8'h00, 0, 0, '0},
      '{8'h00, 0, 0, '0}, '{8'h03, 1, 0, '0}
   };

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      clear_parse();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i])
         offer_byte(directed[i].data_byte, directed[i].last_byte,
                    directed[i].has_size, directed[i].size);

      // mostly well-formed units with random content, the rest noise
      while (bytes_sent < SendTarget) begin
         if ($urandom_range(0, 3) == 0) send_noise();
         else send_sps();
      end
      req_ch.valid = 1'b0;

      // drain owed sizes, then let the finish pass settle
      while (size_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && size_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #4000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* h264_sps_size_parser_core.f */
design/hssp_pkg.sv
design/hssp_if.sv
design/hssp_datapath.sv
design/hssp_ctrl.sv
design/h264_sps_size_parser_core.sv
design/hssp_checker.sv
sim/tb_h264_sps_size_parser_core.sv
